>>> src/apbu_pkg.sv
`timescale 1ns / 1ps
// Shared types, opcodes and register indexes of the ARGB pixel blend unit.
package apbu_pkg;

    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int WGT_W  = 9;
    localparam int PROD_W = CH_W + WGT_W;
    localparam int OP_W   = 4;
    localparam int IDX_W  = 2;
    localparam int NUM_CH = 4;

    localparam logic [WGT_W-1:0] WGT_FULL = WGT_W'(256);
    localparam logic [CH_W-1:0]  CH_MAX   = CH_W'(255);

    typedef enum logic [OP_W-1:0] {
        OP_COPY      = 4'd0,
        OP_OVER      = 4'd1,
        OP_RATE      = 4'd2,
        OP_TINT      = 4'd3,
        OP_MASK_FILL = 4'd4,
        OP_MIX       = 4'd5,
        OP_FADE      = 4'd6,
        OP_COV_COLOR = 4'd7,
        OP_COV_PMUL  = 4'd8,
        OP_SET_ALPHA = 4'd9,
        OP_FILL      = 4'd10
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        REG_BLEND_RATE = 2'd0,
        REG_FILL_COLOR = 2'd1,
        REG_FILL_MASK  = 2'd2
    } t_reg_idx;

    // One channel's job: base*w_base + targ*w_targ, then either floor of the
    // sum over 256 (lerp) or the sum of each product floored separately.
    typedef struct packed {
        logic [CH_W-1:0]  base;
        logic [CH_W-1:0]  targ;
        logic [WGT_W-1:0] w_base;
        logic [WGT_W-1:0] w_targ;
        logic             split;
    } t_lane_ctl;

    function automatic t_lane_ctl lerp_ctl(input logic [CH_W-1:0] base,
                                           input logic [CH_W-1:0] targ,
                                           input logic [WGT_W-1:0] rate);
        t_lane_ctl c;
        c.base   = base;
        c.targ   = targ;
        c.w_base = WGT_FULL - rate;
        c.w_targ = rate;
        c.split  = 1'b0;
        return c;
    endfunction

    function automatic t_lane_ctl keep_ctl(input logic [CH_W-1:0] base);
        t_lane_ctl c;
        c.base   = base;
        c.targ   = '0;
        c.w_base = WGT_FULL;
        c.w_targ = '0;
        c.split  = 1'b1;
        return c;
    endfunction

endpackage

>>> src/argb_pixel_blend_unit.sv
`timescale 1ns / 1ps
// Top level of the ARGB8888 pixel blend unit: config registers and pipeline.
// A beat accepted on start passes the decode, lane product and output registers (three
//   register stages) and then shows its result on o_result_pixel with o_result_valid high.
// Throughput: one pixel per clock; busy stays low since every stage advances each cycle.
// The receiver cannot stall, so results are never held back.
// Reset (synchronous, active low) clears all valid bits and sets blend_rate to 256,
//   fill_color and fill_mask to zero; configuration writes are always ready.
module argb_pixel_blend_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item channel
    input  logic                              start,
    output logic                              busy,
    input  logic [apbu_pkg::OP_W-1:0]         i_opcode,
    input  logic [apbu_pkg::PIX_W-1:0]        i_src_pixel,
    input  logic [apbu_pkg::PIX_W-1:0]        i_second_pixel,
    input  logic [apbu_pkg::PIX_W-1:0]        i_dst_pixel,
    input  logic [apbu_pkg::CH_W-1:0]         i_coverage,
    // Result channel
    output logic                              o_result_valid,
    output logic [apbu_pkg::PIX_W-1:0]        o_result_pixel,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [apbu_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [apbu_pkg::PIX_W-1:0]        i_cfg_data
);

    localparam int CW = apbu_pkg::CH_W;

    logic [apbu_pkg::WGT_W-1:0] r_blend_rate;
    logic [apbu_pkg::PIX_W-1:0] r_fill_color;
    logic [apbu_pkg::PIX_W-1:0] r_fill_mask;

    logic                                       in_fire;
    logic                                       s1_valid;
    logic                                       s1_bypass;
    logic [apbu_pkg::PIX_W-1:0]                 s1_bypass_pixel;
    apbu_pkg::t_lane_ctl [apbu_pkg::NUM_CH-1:0] s1_ctl;

    logic                       r_s2_valid;
    logic                       r_s2_bypass;
    logic [apbu_pkg::PIX_W-1:0] r_s2_bypass_pixel;
    logic [apbu_pkg::PIX_W-1:0] s2_blend_pixel;

    logic                       r_out_valid;
    logic [apbu_pkg::PIX_W-1:0] r_out_pixel;
    logic [apbu_pkg::PIX_W-1:0] n_out_pixel;

    // No backpressure anywhere: every stage advances every cycle.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = start && !busy;

    // Configuration registers; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_rate <= apbu_pkg::WGT_FULL;
            r_fill_color <= '0;
            r_fill_mask  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                apbu_pkg::REG_BLEND_RATE: r_blend_rate <= i_cfg_data[apbu_pkg::WGT_W-1:0];
                apbu_pkg::REG_FILL_COLOR: r_fill_color <= i_cfg_data;
                apbu_pkg::REG_FILL_MASK:  r_fill_mask  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage 1: decode into lane weights or a whole-pixel bypass.
    apbu_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_fire),
        .i_opcode       (i_opcode),
        .i_src_pixel    (i_src_pixel),
        .i_second_pixel (i_second_pixel),
        .i_dst_pixel    (i_dst_pixel),
        .i_coverage     (i_coverage),
        .i_blend_rate   (r_blend_rate),
        .i_fill_color   (r_fill_color),
        .i_fill_mask    (r_fill_mask),
        .o_valid        (s1_valid),
        .o_bypass       (s1_bypass),
        .o_bypass_pixel (s1_bypass_pixel),
        .o_ctl          (s1_ctl)
    );

    // Stage 2: one multiplier pair per channel, alpha in the top lane.
    for (genvar g = 0; g < apbu_pkg::NUM_CH; g++) begin : g_lane
        apbu_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (s1_ctl[g]),
            .o_chan (s2_blend_pixel[g*CW +: CW])
        );
    end

    // Carry the valid bit and bypass pixel alongside the lane products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s2_valid  <= s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_bypass       <= s1_bypass;
        r_s2_bypass_pixel <= s1_bypass_pixel;
    end

    // Stage 3: select the bypass pixel or the combined lanes into the output register.
    assign n_out_pixel = r_s2_bypass ? r_s2_bypass_pixel : s2_blend_pixel;

    always_ff @(posedge i_clk) begin
        r_out_pixel <= n_out_pixel;
    end

    assign o_result_valid = r_out_valid;
    assign o_result_pixel = r_out_pixel;

endmodule

>>> src/apbu_decode.sv
`timescale 1ns / 1ps
// Stage 1: decode the opcode into per-channel weights or a whole-pixel bypass.
module apbu_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [apbu_pkg::OP_W-1:0]           i_opcode,
    input  logic [apbu_pkg::PIX_W-1:0]          i_src_pixel,
    input  logic [apbu_pkg::PIX_W-1:0]          i_second_pixel,
    input  logic [apbu_pkg::PIX_W-1:0]          i_dst_pixel,
    input  logic [apbu_pkg::CH_W-1:0]           i_coverage,
    input  logic [apbu_pkg::WGT_W-1:0]          i_blend_rate,
    input  logic [apbu_pkg::PIX_W-1:0]          i_fill_color,
    input  logic [apbu_pkg::PIX_W-1:0]          i_fill_mask,
    output logic                                o_valid,
    output logic                                o_bypass,
    output logic [apbu_pkg::PIX_W-1:0]          o_bypass_pixel,
    output apbu_pkg::t_lane_ctl [apbu_pkg::NUM_CH-1:0] o_ctl
);

    localparam int CW = apbu_pkg::CH_W;

    logic                                      r_valid;
    logic                                      n_bypass;
    logic                                      r_bypass;
    logic [apbu_pkg::PIX_W-1:0]                n_bypass_pixel;
    logic [apbu_pkg::PIX_W-1:0]                r_bypass_pixel;
    apbu_pkg::t_lane_ctl [apbu_pkg::NUM_CH-1:0] n_ctl;
    apbu_pkg::t_lane_ctl [apbu_pkg::NUM_CH-1:0] r_ctl;

    logic [apbu_pkg::WGT_W-1:0] rate;
    logic [apbu_pkg::WGT_W-1:0] k_src;
    logic [apbu_pkg::WGT_W-1:0] k_cov;
    logic                       rate_full;
    logic                       rate_zero;
    logic [CW-1:0]              dst_a;

    // Channel 3 is alpha, channel 0 is blue.
    function automatic logic [CW-1:0] ch(input logic [apbu_pkg::PIX_W-1:0] p,
                                         input int unsigned idx);
        return p[idx*CW +: CW];
    endfunction

    always_comb begin
        // Rates above 256 saturate.
        rate      = i_blend_rate[apbu_pkg::WGT_W-1] ? apbu_pkg::WGT_FULL : i_blend_rate;
        rate_full = (rate == apbu_pkg::WGT_FULL);
        rate_zero = (rate == '0);
        k_src     = {1'b0, ch(i_src_pixel, 3)} + apbu_pkg::WGT_W'(ch(i_src_pixel, 3) != '0);
        k_cov     = {1'b0, i_coverage} + apbu_pkg::WGT_W'(i_coverage != '0);
        dst_a     = ch(i_dst_pixel, 3);

        n_bypass       = 1'b1;
        n_bypass_pixel = i_dst_pixel;
        for (int i = 0; i < apbu_pkg::NUM_CH; i++) begin
            n_ctl[i] = apbu_pkg::keep_ctl(ch(i_dst_pixel, i));
        end

        case (i_opcode)
            apbu_pkg::OP_COPY: begin
                n_bypass_pixel = i_src_pixel;
            end
            apbu_pkg::OP_OVER: begin
                n_bypass = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    n_ctl[i] = apbu_pkg::lerp_ctl(ch(i_dst_pixel, i), ch(i_src_pixel, i), k_src);
                end
                n_ctl[3].base   = dst_a;
                n_ctl[3].targ   = ch(i_src_pixel, 3);
                n_ctl[3].w_base = apbu_pkg::WGT_FULL - k_src;
                n_ctl[3].w_targ = apbu_pkg::WGT_FULL;
                n_ctl[3].split  = 1'b1;
            end
            apbu_pkg::OP_RATE: begin
                if (rate_full) begin
                    n_bypass_pixel = i_src_pixel;
                end else if (!rate_zero) begin
                    n_bypass = 1'b0;
                    for (int i = 0; i < 4; i++) begin
                        n_ctl[i] = apbu_pkg::lerp_ctl(ch(i_dst_pixel, i),
                                                      ch(i_src_pixel, i), rate);
                    end
                end
            end
            apbu_pkg::OP_TINT: begin
                if (rate_full) begin
                    n_bypass_pixel = i_fill_color;
                end else if (!rate_zero) begin
                    n_bypass = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        n_ctl[i] = apbu_pkg::lerp_ctl(ch(i_dst_pixel, i),
                                                      ch(i_fill_color, i), rate);
                    end
                end
            end
            apbu_pkg::OP_MASK_FILL: begin
                n_bypass_pixel = (i_dst_pixel & i_fill_mask) | (i_fill_color & ~i_fill_mask);
            end
            apbu_pkg::OP_MIX: begin
                if (rate_full) begin
                    n_bypass_pixel = i_src_pixel;
                end else if (rate_zero) begin
                    n_bypass_pixel = i_fill_color;
                end else begin
                    n_bypass = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        n_ctl[i] = apbu_pkg::lerp_ctl(ch(i_fill_color, i),
                                                      ch(i_src_pixel, i), rate);
                    end
                end
            end
            apbu_pkg::OP_FADE: begin
                if (rate_full) begin
                    n_bypass_pixel = i_src_pixel;
                end else if (rate_zero) begin
                    n_bypass_pixel = i_second_pixel;
                end else begin
                    n_bypass = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        n_ctl[i] = apbu_pkg::lerp_ctl(ch(i_second_pixel, i),
                                                      ch(i_src_pixel, i), rate);
                    end
                end
            end
            apbu_pkg::OP_COV_COLOR: begin
                n_bypass = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    n_ctl[i] = apbu_pkg::lerp_ctl(ch(i_dst_pixel, i), ch(i_fill_color, i), k_cov);
                end
            end
            apbu_pkg::OP_COV_PMUL: begin
                n_bypass = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    n_ctl[i].base   = ch(i_dst_pixel, i);
                    n_ctl[i].targ   = (i == 3) ? apbu_pkg::CH_MAX : ch(i_fill_color, i);
                    n_ctl[i].w_base = apbu_pkg::WGT_FULL - k_cov;
                    n_ctl[i].w_targ = k_cov;
                    n_ctl[i].split  = 1'b1;
                end
            end
            apbu_pkg::OP_SET_ALPHA: begin
                n_bypass_pixel = {i_coverage, i_dst_pixel[apbu_pkg::PIX_W-CW-1:0]};
            end
            apbu_pkg::OP_FILL: begin
                n_bypass_pixel = i_fill_color;
            end
            default: begin
                n_bypass_pixel = i_dst_pixel;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bypass       <= n_bypass;
        r_bypass_pixel <= n_bypass_pixel;
        r_ctl          <= n_ctl;
    end

    assign o_valid        = r_valid;
    assign o_bypass       = r_bypass;
    assign o_bypass_pixel = r_bypass_pixel;
    assign o_ctl          = r_ctl;

endmodule

>>> src/apbu_lane.sv
`timescale 1ns / 1ps
// Stage 2 of one channel: register both weighted products; combine them after.
module apbu_lane (
    input  logic                        i_clk,
    input  apbu_pkg::t_lane_ctl         i_ctl,
    output logic [apbu_pkg::CH_W-1:0]   o_chan
);

    localparam int PW = apbu_pkg::PROD_W;
    localparam int CW = apbu_pkg::CH_W;

    logic [PW-1:0] r_prod_base;
    logic [PW-1:0] r_prod_targ;
    logic          r_split;
    logic [PW:0]   sum_lerp;
    logic [PW-CW-1:0] sum_split;

    always_ff @(posedge i_clk) begin
        r_prod_base <= PW'(i_ctl.base) * PW'(i_ctl.w_base);
        r_prod_targ <= PW'(i_ctl.targ) * PW'(i_ctl.w_targ);
        r_split     <= i_ctl.split;
    end

    always_comb begin
        sum_lerp  = {1'b0, r_prod_base} + {1'b0, r_prod_targ};
        sum_split = r_prod_base[PW-1:CW] + r_prod_targ[PW-1:CW];
    end

    assign o_chan = r_split ? sum_split[CW-1:0] : sum_lerp[2*CW-1:CW];

endmodule
